/* sv/lec_pkg.sv */
package lec_pkg;

   localparam int TAPS           = 320;
   localparam int COEF_FRAC_BITS = 32;
   localparam int COEF_WIDTH     = 40;
   localparam int SAMPLE_W       = 16;
   localparam int ACC_W          = 64;
   localparam int SHIFT_W        = 6;
   localparam int UPD_W          = 2 * SAMPLE_W;
   localparam int PROD_W         = COEF_WIDTH + SAMPLE_W;
   localparam int ADDR_W         = $clog2(TAPS);
   localparam int CNT_W          = $clog2(TAPS + 1);
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;
   localparam int CSR_IW         = CSR_AW - 2;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET      = SHIFT_W'(8);
   localparam logic [CSR_IW-1:0]  REG_UPDATE_SHIFT = CSR_IW'(0);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MAC,
      ST_ERR_SUB,
      ST_ERR_RND,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                         valid;
      logic [ADDR_W-1:0]            addr;
      logic signed [COEF_WIDTH-1:0] coef;
   } tap_tag_type;

endpackage

/* sv/lec_mul.sv */
module lec_mul import lec_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  tap_tag_type                  tag_in,
   input  logic signed [COEF_WIDTH-1:0] op_a,
   input  logic signed [SAMPLE_W-1:0]   op_b,
   output tap_tag_type                  tag_out,
   output logic signed [PROD_W-1:0]     prod
);

   tap_tag_type              tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a * op_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign tag_out = tag_ff;
   assign prod    = prod_ff;

endmodule

/* sv/lms_echo_canceller.sv */
// LMS echo canceller, one shared MAC unit, one transaction at a time.
// Each input transaction makes two passes before its result is valid:
//   one pass over the taps for the estimate, one for the coefficient update.
// A new transaction is taken only after the last result is issued; a stalled result holds it off.
// Reset: synchronous; a clearing pass over all TAPS entries zeroes both memories, req_ready low.
module lms_echo_canceller import lec_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_far_sample,
   input  logic signed [SAMPLE_W-1:0] req_near_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_error_sample,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [CSR_AW-1:0]          csr_paddr,
   input  logic [CSR_DW-1:0]          csr_pwdata,
   output logic [CSR_DW-1:0]          csr_prdata,
   output logic                       csr_pready
);

   localparam int Q_W = ACC_W - COEF_FRAC_BITS + 1;
   localparam logic signed [Q_W-1:0] Q_HI = Q_W'(2 ** (SAMPLE_W - 1) - 1);
   localparam logic signed [Q_W-1:0] Q_LO = ~Q_HI;
   localparam logic signed [COEF_WIDTH-1:0] C_MAX = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] C_MIN = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

   logic signed [COEF_WIDTH-1:0] coef_mem [TAPS];
   logic signed [SAMPLE_W-1:0]   dly_mem  [TAPS];

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             tap_ff, tap_in;
   logic [ADDR_W-1:0]            phys_ff, phys_in;
   logic [ADDR_W-1:0]            ptr_ff, ptr_in;
   logic [SHIFT_W-1:0]           shift_ff, shift_in;
   logic signed [SAMPLE_W-1:0]   near_ff, near_in;
   logic signed [ACC_W-1:0]      acc_ff, acc_in;
   logic signed [ACC_W-1:0]      efull_ff, efull_in;
   logic signed [SAMPLE_W-1:0]   err_ff, err_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0]   rsp_data_ff, rsp_data_in;

   logic                         s1_valid_ff;
   logic [ADDR_W-1:0]            s1_addr_ff;
   logic signed [COEF_WIDTH-1:0] coef_rd_ff;
   logic signed [SAMPLE_W-1:0]   dly_rd_ff;

   logic                         s3_valid_ff;
   logic [ADDR_W-1:0]            s3_addr_ff;
   logic signed [COEF_WIDTH-1:0] s3_coef_ff;
   logic signed [UPD_W-1:0]      s3_delta_ff;

   tap_tag_type                  mul_tag_in, mul_tag;
   logic signed [COEF_WIDTH-1:0] mul_a;
   logic signed [PROD_W-1:0]     mul_prod;
   logic signed [UPD_W-1:0]      delta;

   logic                         accept;
   logic                         issue;
   logic                         slot_free;
   logic                         csr_write;
   logic                         pass_done;
   logic signed [Q_W-1:0]        q;
   logic signed [COEF_WIDTH:0]   sum;
   logic signed [COEF_WIDTH-1:0] sat_sum;

   logic                         coef_we;
   logic [ADDR_W-1:0]            coef_wa;
   logic signed [COEF_WIDTH-1:0] coef_wd;
   logic                         dly_we;
   logic [ADDR_W-1:0]            dly_wa;
   logic signed [SAMPLE_W-1:0]   dly_wd;

   assign accept    = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign issue     = (state_ff == ST_MAC || state_ff == ST_UPD) && (tap_ff < CNT_W'(TAPS));
   assign pass_done = (tap_ff == CNT_W'(TAPS)) && !s1_valid_ff && !mul_tag.valid && !s3_valid_ff;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (tap_ff == CNT_W'(TAPS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_MAC;
         end
         ST_MAC: begin
            if (pass_done) state_in = ST_ERR_SUB;
         end
         ST_ERR_SUB: state_in = ST_ERR_RND;
         ST_ERR_RND: state_in = ST_UPD;
         ST_UPD: begin
            if (pass_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      tap_in    = tap_ff;
      phys_in   = phys_ff;
      ptr_in    = ptr_ff;
      near_in   = near_ff;
      acc_in    = acc_ff;
      efull_in  = efull_ff;
      err_in    = err_ff;
      case (state_ff)
         ST_CLEAR: begin
            tap_in = (tap_ff == CNT_W'(TAPS - 1)) ? '0 : tap_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               tap_in  = '0;
               phys_in = ptr_ff;
               near_in = req_near_sample;
               acc_in  = '0;
            end
         end
         ST_MAC: begin
            if (mul_tag.valid) begin
               acc_in = acc_ff + {{(ACC_W - PROD_W){mul_prod[PROD_W-1]}}, mul_prod};
            end
         end
         ST_ERR_SUB: begin
            efull_in = ({{(ACC_W - SAMPLE_W){near_ff[SAMPLE_W-1]}}, near_ff} << COEF_FRAC_BITS)
                       - acc_ff;
         end
         ST_ERR_RND: begin
            if (q > Q_HI) begin
               err_in = SAMPLE_W'(Q_HI);
            end else if (q < Q_LO) begin
               err_in = SAMPLE_W'(Q_LO);
            end else begin
               err_in = q[SAMPLE_W-1:0];
            end
            tap_in  = '0;
            phys_in = ptr_ff;
         end
         ST_DONE: begin
            if (slot_free) begin
               ptr_in = (ptr_ff == '0) ? ADDR_W'(TAPS - 1) : ptr_ff - ADDR_W'(1);
            end
         end
         default: ;
      endcase
      if (issue) begin
         tap_in  = tap_ff + CNT_W'(1);
         phys_in = (phys_ff == ADDR_W'(TAPS - 1)) ? '0 : phys_ff + ADDR_W'(1);
      end
   end

   assign q = $signed({efull_ff[ACC_W-1], efull_ff[ACC_W-1:COEF_FRAC_BITS]})
              + $signed({{(Q_W - 1){1'b0}}, efull_ff[COEF_FRAC_BITS-1]});

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = err_ff;
      end
   end

   always_comb begin
      shift_in = shift_ff;
      if (csr_write && csr_paddr[CSR_AW-1:2] == REG_UPDATE_SHIFT) begin
         shift_in = csr_pwdata[SHIFT_W-1:0];
      end
   end

   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == REG_UPDATE_SHIFT) ?
                       {{(CSR_DW - SHIFT_W){1'b0}}, shift_ff} : '0;
   assign csr_pready = 1'b1;

   // shared MAC datapath
   assign mul_a      = (state_ff == ST_UPD) ?
                       {{(COEF_WIDTH - SAMPLE_W){err_ff[SAMPLE_W-1]}}, err_ff} : coef_rd_ff;
   assign mul_tag_in = '{valid: s1_valid_ff, addr: s1_addr_ff, coef: coef_rd_ff};

   lec_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .tag_in  (mul_tag_in),
      .op_a    (mul_a),
      .op_b    (dly_rd_ff),
      .tag_out (mul_tag),
      .prod    (mul_prod)
   );

   assign delta = $signed(mul_prod[UPD_W-1:0]) >>> shift_ff;

   assign sum = {s3_coef_ff[COEF_WIDTH-1], s3_coef_ff}
                + {{(COEF_WIDTH + 1 - UPD_W){s3_delta_ff[UPD_W-1]}}, s3_delta_ff};

   always_comb begin
      if (sum[COEF_WIDTH] != sum[COEF_WIDTH-1]) begin
         sat_sum = sum[COEF_WIDTH] ? C_MIN : C_MAX;
      end else begin
         sat_sum = sum[COEF_WIDTH-1:0];
      end
   end

   always_comb begin
      coef_we = (state_ff == ST_CLEAR) || s3_valid_ff;
      coef_wa = (state_ff == ST_CLEAR) ? tap_ff[ADDR_W-1:0] : s3_addr_ff;
      coef_wd = (state_ff == ST_CLEAR) ? '0 : sat_sum;
      dly_we  = (state_ff == ST_CLEAR) || accept;
      dly_wa  = (state_ff == ST_CLEAR) ? tap_ff[ADDR_W-1:0] : ptr_ff;
      dly_wd  = (state_ff == ST_CLEAR) ? '0 : req_far_sample;
   end

   always_ff @(posedge clock) begin
      if (coef_we) coef_mem[coef_wa] <= coef_wd;
      if (issue) coef_rd_ff <= coef_mem[tap_ff[ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (dly_we) dly_mem[dly_wa] <= dly_wd;
      if (issue) dly_rd_ff <= dly_mem[phys_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         tap_ff       <= '0;
         phys_ff      <= '0;
         ptr_ff       <= '0;
         shift_ff     <= SHIFT_RESET;
         rsp_valid_ff <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tap_ff       <= tap_in;
         phys_ff      <= phys_in;
         ptr_ff       <= ptr_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_valid_ff  <= issue;
         s3_valid_ff  <= mul_tag.valid && (state_ff == ST_UPD);
      end
   end

   always_ff @(posedge clock) begin
      near_ff     <= near_in;
      acc_ff      <= acc_in;
      efull_ff    <= efull_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
      s1_addr_ff  <= tap_ff[ADDR_W-1:0];
      s3_addr_ff  <= mul_tag.addr;
      s3_coef_ff  <= mul_tag.coef;
      s3_delta_ff <= delta;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_error_sample = rsp_data_ff;

endmodule

/* sv/lec_checker.sv */
module lec_checker import lec_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_error_sample,
   input logic                       csr_psel,
   input logic                       csr_penable,
   input logic                       csr_pready
);

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_error_sample))
      else $error("result dropped or changed while stalled");

   // one transaction in flight: busy right after accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while a transaction is in flight");

   // a result never appears the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("result appeared too early");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable |-> csr_pready)
      else $error("csr access stalled");

endmodule

bind lms_echo_canceller lec_checker u_lec_checker (.*);
